// ===== rtl/ptssp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptssp_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_YAW_MIN   = 3'd0;
   localparam logic [2:0] REG_YAW_MAX   = 3'd1;
   localparam logic [2:0] REG_PITCH_MIN = 3'd2;
   localparam logic [2:0] REG_PITCH_MAX = 3'd3;
   localparam logic [2:0] REG_MOTION_EN = 3'd4;

   localparam logic signed [8:0]  SCALE_OFFSET = 9'sd100;
   localparam logic signed [8:0]  SCALE_SPAN   = 9'sd200;
   localparam logic signed [17:0] POS_HI       = 18'sd100;
   localparam logic signed [17:0] POS_LO       = -18'sd100;
   localparam logic [7:0]         SERVO_TOP    = 8'd180;
   localparam logic [7:0]         SERVO_CENTRE = 8'd90;

   // x / 200 == ((x >> 3) * 10486) >> 18 for x below 2^16
   localparam logic [13:0] RECIP_25    = 14'd10486;
   localparam int          RECIP_SHIFT = 18;

   localparam int DIV_W     = 16;
   localparam int DIV_CNT_W = 4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_GMUL,
      OP_GRECIP,
      OP_STEP,
      OP_PNUM,
      OP_DSTART,
      OP_PDONE,
      OP_TOL,
      OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GMUL,
      ST_GRECIP,
      ST_STEP,
      ST_PNUM,
      ST_DSTART,
      ST_DWAIT,
      ST_PDONE,
      ST_TOL,
      ST_OUT
   } state_type;

   typedef struct packed {
      op_type op;
      logic   sel;
   } cmd_type;

   typedef struct packed {
      logic span_zero;
      logic div_done;
      logic out_full;
   } status_type;

   typedef struct packed {
      logic [7:0] yaw_min;
      logic [7:0] yaw_max;
      logic [7:0] pitch_min;
      logic [7:0] pitch_max;
      logic       motion_en;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/pan_tilt_servo_slew_positioner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pan/tilt servo positioner. Each request transaction carries a yaw and a pitch target,
// saturated to -100..100 and mapped onto the configured angle range of each axis; with
// motion enabled each servo angle steps one degree toward its mapped target. The response
// gives both angles, both angles mapped back to -100..100 and an aligned flag. Both
// angles reset to 90. Requests are taken one at a time; the next one can be taken in the
// same cycle that the response is first presented. Most of a transaction is spent in
// two passes through the shared 16-step restoring divider (one per axis); an axis
// whose minimum equals its maximum skips the divider. A new request is accepted while
// the previous response is still waiting; its own response then waits until the
// earlier one has been taken.

module pan_tilt_servo_slew_positioner
   import ptssp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,   // yaw_target[15:0], pitch_target[31:16]

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [39:0]                rsp_tdata,   // yaw_angle[7:0], pitch_angle[15:8],
                                                   // yaw_position[23:16],
                                                   // pitch_position[31:24], aligned[32]

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   ptssp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ptssp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ptssp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== rtl/ptssp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptssp_div
   import ptssp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [7:0]       divisor,
   output logic      [DIV_W-1:0] quotient,
   output logic                  done
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [7:0]           rem_ff;
   logic [7:0]           dvs_ff;
   logic [DIV_W-1:0]     quo_ff;

   logic [8:0] shifted;
   logic [8:0] trial;
   logic       ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
         rem_ff <= ge ? trial[7:0] : shifted[7:0];
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== rtl/ptssp_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptssp_csr
   import ptssp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   logic [2:0] index;
   logic       wr;

   assign index  = paddr[4:2];
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yaw_min   <= 8'd0;
         cfg_ff.yaw_max   <= SERVO_TOP;
         cfg_ff.pitch_min <= 8'd0;
         cfg_ff.pitch_max <= SERVO_TOP;
         cfg_ff.motion_en <= 1'b1;
      end else if (wr) begin
         case (index)
            REG_YAW_MIN:   cfg_ff.yaw_min   <= pwdata[7:0];
            REG_YAW_MAX:   cfg_ff.yaw_max   <= pwdata[7:0];
            REG_PITCH_MIN: cfg_ff.pitch_min <= pwdata[7:0];
            REG_PITCH_MAX: cfg_ff.pitch_max <= pwdata[7:0];
            REG_MOTION_EN: cfg_ff.motion_en <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_YAW_MIN:   prdata = CSR_DATA_W'(cfg_ff.yaw_min);
         REG_YAW_MAX:   prdata = CSR_DATA_W'(cfg_ff.yaw_max);
         REG_PITCH_MIN: prdata = CSR_DATA_W'(cfg_ff.pitch_min);
         REG_PITCH_MAX: prdata = CSR_DATA_W'(cfg_ff.pitch_max);
         REG_MOTION_EN: prdata = CSR_DATA_W'(cfg_ff.motion_en);
         default:       prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/ptssp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptssp_datapath
   import ptssp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire cfg_type     cfg,
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata
);

   function automatic logic signed [7:0] sat_target(input logic signed [15:0] v);
      logic signed [7:0] r;
      if (v < -16'sd100) begin
         r = -8'sd100;
      end else if (v > 16'sd100) begin
         r = 8'sd100;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   logic signed [7:0]  tgt_ff [2];
   logic [7:0]         ang_ff [2];
   logic               ok_ff  [2];
   logic signed [7:0]  psat_ff [2];
   logic signed [16:0] prod_ff;
   logic [7:0]         gq_ff;
   logic               gneg_ff;
   logic [DIV_W-1:0]   dividend_ff;
   logic               pneg_ff;
   logic signed [17:0] pos_ff;
   logic [16:0]        dist_ff;
   logic               out_full_ff;
   logic [39:0]        out_data_ff;

   logic               sel;
   logic [7:0]         mn;
   logic [7:0]         mx;
   logic signed [8:0]  span;
   logic [7:0]         abs_span;
   logic signed [7:0]  t_sel;
   logic signed [8:0]  u;
   logic signed [17:0] prod_full;
   logic [15:0]        gmag;
   logic [26:0]        recip_prod;
   logic [7:0]         goal;
   logic [7:0]         a_cur;
   logic [7:0]         ang_in;
   logic signed [8:0]  diff;
   logic signed [17:0] num_full;
   logic [DIV_W-1:0]   quotient;
   logic               div_done;
   logic signed [17:0] qs;
   logic signed [17:0] pos_in;
   logic signed [17:0] dev;
   logic [24:0]        tol_prod;
   logic signed [7:0]  psat_in;

   assign sel      = cmd.sel;
   assign mn       = sel ? cfg.pitch_min : cfg.yaw_min;
   assign mx       = sel ? cfg.pitch_max : cfg.yaw_max;
   assign span     = signed'({1'b0, mx}) - signed'({1'b0, mn});
   assign abs_span = span[8] ? 8'(-span) : span[7:0];
   assign t_sel    = tgt_ff[sel];
   assign u        = signed'({t_sel[7], t_sel}) + SCALE_OFFSET;
   assign a_cur    = ang_ff[sel];

   always_comb begin
      prod_full  = u * span;
      gmag       = prod_ff[16] ? 16'(-prod_ff) : prod_ff[15:0];
      recip_prod = 27'(gmag[15:3]) * 27'(RECIP_25);
      goal       = gneg_ff ? (mn - gq_ff) : (mn + gq_ff);

      ang_in = a_cur;
      if (cfg.motion_en) begin
         if (goal > a_cur) begin
            if (a_cur < SERVO_TOP) begin
               ang_in = a_cur + 8'd1;
            end
         end else if (goal < a_cur) begin
            ang_in = a_cur - 8'd1;
         end
      end

      diff     = signed'({1'b0, a_cur}) - signed'({1'b0, mn});
      num_full = diff * SCALE_SPAN;

      qs     = pneg_ff ? -signed'({2'b00, quotient}) : signed'({2'b00, quotient});
      pos_in = qs - POS_HI;
      dev    = pos_in - 18'(t_sel);

      tol_prod = 25'(dist_ff) * 25'(abs_span);
      if (pos_ff < POS_LO) begin
         psat_in = -8'sd100;
      end else if (pos_ff > POS_HI) begin
         psat_in = 8'sd100;
      end else begin
         psat_in = pos_ff[7:0];
      end
   end

   ptssp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DSTART),
      .dividend (dividend_ff),
      .divisor  (abs_span),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            tgt_ff[0] <= sat_target(req_tdata[15:0]);
            tgt_ff[1] <= sat_target(req_tdata[31:16]);
         end
         OP_GMUL: begin
            prod_ff <= prod_full[16:0];
         end
         OP_GRECIP: begin
            gq_ff   <= recip_prod[RECIP_SHIFT +: 8];
            gneg_ff <= prod_ff[16];
         end
         OP_PNUM: begin
            dividend_ff <= num_full[17] ? DIV_W'(-num_full) : num_full[DIV_W-1:0];
            pneg_ff     <= num_full[17] ^ span[8];
         end
         OP_PDONE: begin
            pos_ff  <= pos_in;
            dist_ff <= dev[17] ? 17'(-dev) : dev[16:0];
         end
         OP_TOL: begin
            if (span == 9'sd0) begin
               ok_ff[sel]   <= 1'b1;
               psat_ff[sel] <= -8'sd100;
            end else begin
               ok_ff[sel]   <= (tol_prod <= 25'(SCALE_SPAN));
               psat_ff[sel] <= psat_in;
            end
         end
         OP_OUT: begin
            out_data_ff <= {7'd0, ok_ff[0] & ok_ff[1], psat_ff[1], psat_ff[0],
                            ang_ff[1], ang_ff[0]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff[0]   <= SERVO_CENTRE;
         ang_ff[1]   <= SERVO_CENTRE;
         out_full_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_STEP) begin
            ang_ff[sel] <= ang_in;
         end
         if (cmd.op == OP_OUT) begin
            out_full_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_full_ff <= 1'b0;
         end
      end
   end

   assign status.span_zero = (span == 9'sd0);
   assign status.div_done  = div_done;
   assign status.out_full  = out_full_ff;

   assign rsp_tvalid = out_full_ff;
   assign rsp_tdata  = out_data_ff;

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      (ang_ff[0] <= SERVO_TOP) && (ang_ff[1] <= SERVO_TOP))
      else $error("servo angle beyond travel");

   a_slew_one_degree: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_STEP && !cmd.sel) |=>
         (ang_ff[0] == $past(ang_ff[0]) || ang_ff[0] == $past(ang_ff[0]) + 8'd1 ||
          ang_ff[0] == $past(ang_ff[0]) - 8'd1))
      else $error("yaw angle moved by more than one degree");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |-> !out_full_ff)
      else $error("result register overwritten before transaction");

   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DSTART) |=> !div_done)
      else $error("divider finished too early");

endmodule

`default_nettype wire

// ===== rtl/ptssp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptssp_ctrl
   import ptssp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      sel_in     = sel_ff;
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.sel    = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               sel_in   = 1'b0;
               state_in = ST_GMUL;
            end
         end
         ST_GMUL: begin
            cmd.op   = OP_GMUL;
            state_in = ST_GRECIP;
         end
         ST_GRECIP: begin
            cmd.op   = OP_GRECIP;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.op   = OP_STEP;
            state_in = ST_PNUM;
         end
         ST_PNUM: begin
            cmd.op   = OP_PNUM;
            state_in = status.span_zero ? ST_TOL : ST_DSTART;
         end
         ST_DSTART: begin
            cmd.op   = OP_DSTART;
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (status.div_done) begin
               state_in = ST_PDONE;
            end
         end
         ST_PDONE: begin
            cmd.op   = OP_PDONE;
            state_in = ST_TOL;
         end
         ST_TOL: begin
            cmd.op = OP_TOL;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_GMUL;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!status.out_full) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
